/* design/sec2cal_pkg.sv */
// Package for the seconds to calendar converter: time constants, reciprocal
// multipliers for the constant divisions, and the month table with its lookup.
// No dependencies.
package sec2cal_pkg;

  localparam int unsigned SECS_PER_YEAR = 31536000;
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;

  // Reciprocals: each quotient estimate is low by at most one.
  localparam int unsigned YEAR_MUL = 136;  // 2^25 / (31536000 >> 7)
  localparam int unsigned DAY_MUL  = 388;  // 2^18 / (86400 >> 7)
  localparam int unsigned HOUR_MUL = 36;   // 2^13 / (3600 >> 4)
  localparam int unsigned MIN_MUL  = 68;   // 2^10 / (60 >> 2)

  localparam int unsigned NUM_STAGES = 13;

  typedef logic [8:0] doy_t;

  // First zero-based day of year of each month in a common year.
  localparam doy_t MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] dom;
  } month_day_t;

  // Fields of the result that are settled early and ride down the pipeline.
  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] dom;
    logic [4:0] hh;
  } cal_t;

  function automatic month_day_t month_of_day(input doy_t doy);
    month_day_t res;
    logic [3:0] idx;
    doy_t       diff;
    idx = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (doy >= MONTH_START[m]) begin
        idx = 4'(m);
      end
    end
    diff      = doy - MONTH_START[idx];
    res.month = idx + 4'd1;
    res.dom   = diff[4:0] + 5'd1;
    return res;
  endfunction

endpackage

/* design/seconds_to_month_day_hms.sv */
// A word passes through 13 register stages, a to m, the input register included;
// its result is valid at the output register m.
// Throughput: one word per cycle; the 13-stage pipeline advances as a whole
// whenever the output register is empty or its word is being taken.
// Reset (rst_n low, synchronous) clears all stage valid bits; data registers are not reset.
// Converter of elapsed seconds to 365-day year offset, month, day and time of day.
// Depends on sec2cal_pkg.
module seconds_to_month_day_hms
  import sec2cal_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_elapsed_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_year_offset,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hours,
  output logic [5:0]  out_minutes,
  output logic [5:0]  out_seconds
);

  logic [NUM_STAGES-1:0] vld_r;
  logic                  en;

  // Year split: estimate, remainder, correction.
  logic [31:0] a_x_r;
  logic [31:0] b_x_r;
  logic [7:0]  b_qe_r, b_qe_nxt;
  logic [7:0]  c_q_r;
  logic [25:0] c_rem_r, c_rem_nxt;
  logic [7:0]  d_year_r, d_year_nxt;
  logic [24:0] d_rem_r, d_rem_nxt;
  // Day split.
  logic [7:0]  e_year_r, f_year_r, g_year_r;
  logic [24:0] e_rem_r;
  logic [8:0]  e_de_r, e_de_nxt, f_de_r;
  logic [17:0] f_r2_r, f_r2_nxt;
  logic [8:0]  g_doy_r, g_doy_nxt;
  logic [16:0] g_sod_r, g_sod_nxt;
  // Hour split and month lookup.
  cal_t        h_cal_r, h_cal_nxt, i_cal_r, j_cal_r, k_cal_r, l_cal_r;
  logic [16:0] h_sod_r;
  logic [4:0]  h_he_r, h_he_nxt;
  logic [12:0] i_r3_r, i_r3_nxt;
  logic [4:0]  j_hh_nxt;
  logic [11:0] j_ms_r, j_ms_nxt, k_ms_r;
  // Minute split.
  logic [5:0]  k_me_r, k_me_nxt, l_me_r;
  logic [6:0]  l_r4_r, l_r4_nxt;
  logic [5:0]  m_mm_nxt, m_ss_nxt;
  cal_t        m_cal_r;
  logic [5:0]  m_mm_r, m_ss_r;

  logic [32:0] b_prod, c_diff;
  logic [26:0] e_prod;
  logic [24:0] f_diff;
  logic [18:0] h_prod;
  logic [16:0] i_diff, k_prod;
  logic [11:0] l_diff;
  month_day_t  h_md;

  assign en       = ~vld_r[NUM_STAGES-1] | out_ready;
  assign in_ready = en;

  always_comb begin
    // Year estimate and remainder.
    b_prod   = 33'(a_x_r[31:7]) * 33'(YEAR_MUL);
    b_qe_nxt = b_prod[32:25];
    c_diff    = {1'b0, b_x_r} - 33'(b_qe_r) * 33'(SECS_PER_YEAR);
    c_rem_nxt = c_diff[25:0];
    if (c_rem_r >= 26'(SECS_PER_YEAR)) begin
      d_year_nxt = c_q_r + 8'd1;
      d_rem_nxt  = 25'(c_rem_r - 26'(SECS_PER_YEAR));
    end else begin
      d_year_nxt = c_q_r;
      d_rem_nxt  = c_rem_r[24:0];
    end

    // Day estimate and remainder.
    e_prod   = 27'(d_rem_r[24:7]) * 27'(DAY_MUL);
    e_de_nxt = e_prod[26:18];
    f_diff   = e_rem_r - 25'(e_de_r) * 25'(SECS_PER_DAY);
    f_r2_nxt = f_diff[17:0];
    if (f_r2_r >= 18'(SECS_PER_DAY)) begin
      g_doy_nxt = f_de_r + 9'd1;
      g_sod_nxt = 17'(f_r2_r - 18'(SECS_PER_DAY));
    end else begin
      g_doy_nxt = f_de_r;
      g_sod_nxt = f_r2_r[16:0];
    end

    // Month lookup and hour estimate.
    h_prod   = 19'(g_sod_r[16:4]) * 19'(HOUR_MUL);
    h_he_nxt = h_prod[17:13];
    h_md            = month_of_day(g_doy_r);
    h_cal_nxt.year  = g_year_r;
    h_cal_nxt.month = h_md.month;
    h_cal_nxt.dom   = h_md.dom;
    h_cal_nxt.hh    = h_he_nxt;
    i_diff   = h_sod_r - 17'(h_he_r) * 17'(SECS_PER_HOUR);
    i_r3_nxt = i_diff[12:0];
    if (i_r3_r >= 13'(SECS_PER_HOUR)) begin
      j_hh_nxt = i_cal_r.hh + 5'd1;
      j_ms_nxt = 12'(i_r3_r - 13'(SECS_PER_HOUR));
    end else begin
      j_hh_nxt = i_cal_r.hh;
      j_ms_nxt = i_r3_r[11:0];
    end

    // Minute estimate and remainder.
    k_prod   = 17'(j_ms_r[11:2]) * 17'(MIN_MUL);
    k_me_nxt = k_prod[15:10];
    l_diff   = k_ms_r - 12'(k_me_r) * 12'(SECS_PER_MIN);
    l_r4_nxt = l_diff[6:0];
    if (l_r4_r >= 7'(SECS_PER_MIN)) begin
      m_mm_nxt = l_me_r + 6'd1;
      m_ss_nxt = 6'(l_r4_r - 7'(SECS_PER_MIN));
    end else begin
      m_mm_nxt = l_me_r;
      m_ss_nxt = l_r4_r[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NUM_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x_r    <= in_elapsed_seconds;
      b_x_r    <= a_x_r;
      b_qe_r   <= b_qe_nxt;
      c_q_r    <= b_qe_r;
      c_rem_r  <= c_rem_nxt;
      d_year_r <= d_year_nxt;
      d_rem_r  <= d_rem_nxt;
      e_year_r <= d_year_r;
      e_rem_r  <= d_rem_r;
      e_de_r   <= e_de_nxt;
      f_year_r <= e_year_r;
      f_de_r   <= e_de_r;
      f_r2_r   <= f_r2_nxt;
      g_year_r <= f_year_r;
      g_doy_r  <= g_doy_nxt;
      g_sod_r  <= g_sod_nxt;
      h_cal_r  <= h_cal_nxt;
      h_sod_r  <= g_sod_r;
      h_he_r   <= h_he_nxt;
      i_cal_r  <= h_cal_r;
      i_r3_r   <= i_r3_nxt;
      j_cal_r  <= {i_cal_r.year, i_cal_r.month, i_cal_r.dom, j_hh_nxt};
      j_ms_r   <= j_ms_nxt;
      k_cal_r  <= j_cal_r;
      k_ms_r   <= j_ms_r;
      k_me_r   <= k_me_nxt;
      l_cal_r  <= k_cal_r;
      l_me_r   <= k_me_r;
      l_r4_r   <= l_r4_nxt;
      m_cal_r  <= l_cal_r;
      m_mm_r   <= m_mm_nxt;
      m_ss_r   <= m_ss_nxt;
    end
  end

  assign out_valid        = vld_r[NUM_STAGES-1];
  assign out_year_offset  = m_cal_r.year;
  assign out_month        = m_cal_r.month;
  assign out_day_of_month = m_cal_r.dom;
  assign out_hours        = m_cal_r.hh;
  assign out_minutes      = m_mm_r;
  assign out_seconds      = m_ss_r;

endmodule

/* design/sec2cal_checker.sv */
// Port-level checker for seconds_to_month_day_hms, attached with a bind.
// Depends on sec2cal_pkg only through the bound top level.
module sec2cal_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] in_elapsed_seconds,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_year_offset,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day_of_month,
  input logic [4:0]  out_hours,
  input logic [5:0]  out_minutes,
  input logic [5:0]  out_seconds
);

  // A stalled result word holds still.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_year_offset) &&
      $stable(out_month) && $stable(out_day_of_month) && $stable(out_hours) &&
      $stable(out_minutes) && $stable(out_seconds))
    else $error("stalled result word changed");

  // The pipeline empties on reset.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The input side advances exactly when the output register can move.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output flow");

  // Every delivered date and time is in range.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_year_offset <= 8'd136 && out_month >= 4'd1 &&
      out_month <= 4'd12 && out_day_of_month >= 5'd1 && out_day_of_month <= 5'd31 &&
      out_hours <= 5'd23 && out_minutes <= 6'd59 && out_seconds <= 6'd59)
    else $error("result field out of range");

endmodule

bind seconds_to_month_day_hms sec2cal_checker u_sec2cal_checker (.*);

/* tb/seconds_to_month_day_hms_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for seconds_to_month_day_hms: directed and random second
// counts go in, calendar words come out and are checked against a local predictor.
// Depends on the RTL of seconds_to_month_day_hms only.
module seconds_to_month_day_hms_test;

  localparam int unsigned YEAR_SECS = 31536000;
  localparam int unsigned DAY_SECS  = 86400;
  localparam int unsigned HOUR_SECS = 3600;
  localparam int unsigned MIN_SECS  = 60;
  localparam int unsigned LAST_YEAR_BASE = 136 * YEAR_SECS;
  localparam int          RANDOM_COUNTS = 1030;
  localparam int          DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] year_offset;
    logic [3:0] month;
    logic [4:0] day_of_month;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } calendar_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_elapsed_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_year_offset;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hours;
  logic [5:0]  out_minutes;
  logic [5:0]  out_seconds;

  logic [31:0] counts_to_send [$];
  calendar_t   calendar_due [$];
  logic        in_taken = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          faults = 0;
  int          words_checked = 0;
  int          top_year_seen = 0;
  logic [12:0] months_seen = '0;

  seconds_to_month_day_hms dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_elapsed_seconds (in_elapsed_seconds),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_year_offset    (out_year_offset),
    .out_month          (out_month),
    .out_day_of_month   (out_day_of_month),
    .out_hours          (out_hours),
    .out_minutes        (out_minutes),
    .out_seconds        (out_seconds)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned month_first_day(input int m);
    case (m)
      0:       return 0;
      1:       return 31;
      2:       return 59;
      3:       return 90;
      4:       return 120;
      5:       return 151;
      6:       return 181;
      7:       return 212;
      8:       return 243;
      9:       return 273;
      10:      return 304;
      default: return 334;
    endcase
  endfunction

  function automatic calendar_t calendar_of(input logic [31:0] count);
    calendar_t   cal;
    int unsigned yr, rem, doy, sod, hh, mm;
    int          m;
    yr  = count / YEAR_SECS;
    rem = count - yr * YEAR_SECS;
    doy = rem / DAY_SECS;
    sod = (rem - doy * DAY_SECS) & 32'h1FFFF;
    m = 11;
    while (m > 0 && doy < month_first_day(m)) m--;
    hh = sod / HOUR_SECS;
    mm = (sod - hh * HOUR_SECS) / MIN_SECS;
    cal.year_offset  = 8'(yr);
    cal.month        = 4'(m + 1);
    cal.day_of_month = 5'(doy - month_first_day(m) + 1);
    cal.hours        = 5'(hh);
    cal.minutes      = 6'(mm);
    cal.seconds      = 6'(sod - hh * HOUR_SECS - mm * MIN_SECS);
    return cal;
  endfunction

  function automatic logic [31:0] count_at(input int unsigned yr, input int unsigned doy,
                                           input int unsigned sod);
    return yr * YEAR_SECS + doy * DAY_SECS + sod;
  endfunction

  // Idle bursts only in two of every three stretches, and never near the end.
  function automatic bit jittery();
    return counts_to_send.size() > 150 && ((counts_to_send.size() / 90) % 3 != 0);
  endfunction

  task automatic note_fault(input string what, input calendar_t want, input calendar_t got);
    faults++;
    if (faults <= 10) begin
      $display("mismatch at %0t: %s", $realtime, what);
      $display("  expected yr=%0d mon=%0d day=%0d %0d:%0d:%0d", want.year_offset,
               want.month, want.day_of_month, want.hours, want.minutes, want.seconds);
      $display("  actual   yr=%0d mon=%0d day=%0d %0d:%0d:%0d", got.year_offset,
               got.month, got.day_of_month, got.hours, got.minutes, got.seconds);
    end
  endtask

  // Expectations are queued when a count is taken; result words are checked in order.
  always @(posedge clk) begin
    calendar_t got, want;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      calendar_due.push_back(calendar_of(in_elapsed_seconds));
    end
    if (rst_n && out_valid && out_ready) begin
      got = {out_year_offset, out_month, out_day_of_month, out_hours, out_minutes,
             out_seconds};
      if (calendar_due.size() == 0) begin
        note_fault("result word with nothing outstanding", '0, got);
      end else begin
        want = calendar_due.pop_front();
        words_checked++;
        if (got.year_offset != want.year_offset || got.month != want.month ||
            got.day_of_month != want.day_of_month || got.hours != want.hours ||
            got.minutes != want.minutes || got.seconds != want.seconds) begin
          note_fault("calendar fields differ", want, got);
        end else begin
          if (want.month <= 12) months_seen[want.month] = 1'b1;
          if (want.year_offset > top_year_seen) top_year_seen = want.year_offset;
        end
      end
    end
  end

  // Sender: holds a word until taken, then maybe idles before the next one.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (counts_to_send.size() != 0) begin
        in_valid <= 1'b1;
        in_elapsed_seconds <= counts_to_send.pop_front();
        if (jittery() && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 18);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: ready most of the time, with stall bursts.
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (jittery() && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 18);
    end
  end

  initial begin
    int          m, sod;
    int unsigned doy;
    // Time-of-day edges, year edges and the extremes of the input.
    counts_to_send.push_back(32'd0);
    counts_to_send.push_back(32'd59);
    counts_to_send.push_back(32'd60);
    counts_to_send.push_back(32'd3599);
    counts_to_send.push_back(32'd3600);
    counts_to_send.push_back(32'd86399);
    counts_to_send.push_back(YEAR_SECS - 1);
    counts_to_send.push_back(YEAR_SECS);
    counts_to_send.push_back(count_at(135, 364, DAY_SECS - 1));
    counts_to_send.push_back(LAST_YEAR_BASE);
    counts_to_send.push_back(32'h8000_0000);
    counts_to_send.push_back(32'hFFFF_FFFF);
    counts_to_send.push_back(count_at(7, 58, DAY_SECS - 1));
    // First day of every month, then the last day of December.
    for (m = 0; m < 12; m++) begin
      counts_to_send.push_back(count_at(3, month_first_day(m), $urandom_range(0, DAY_SECS - 1)));
    end
    counts_to_send.push_back(count_at(42, 364, 0));

    for (int i = 0; i < RANDOM_COUNTS; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: counts_to_send.push_back($urandom);
        3, 4, 5: counts_to_send.push_back(count_at($urandom_range(0, 135),
                                                   $urandom_range(0, 364),
                                                   $urandom_range(0, DAY_SECS - 1)));
        6, 7: begin
          // Straddle a month boundary near midnight.
          m   = $urandom_range(0, 11);
          doy = month_first_day(m);
          if (m > 0 && $urandom_range(0, 1) == 1) doy = doy - 1;
          sod = $urandom_range(0, 1) ? $urandom_range(0, 59)
                                     : DAY_SECS - 60 + $urandom_range(0, 59);
          counts_to_send.push_back(count_at($urandom_range(0, 135), doy, sod));
        end
        8:       counts_to_send.push_back(LAST_YEAR_BASE +
                                          $urandom_range(0, 32'hFFFF_FFFF - LAST_YEAR_BASE));
        default: counts_to_send.push_back($urandom_range(0, 200000));
      endcase
    end

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    while (counts_to_send.size() != 0 || in_valid) @(posedge clk);
    while (calendar_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d calendar words covering %0d of 12 months, year offsets up to %0d.",
             words_checked, $countones(months_seen), top_year_seen);
    $display("Mismatches counted: %0d.", faults);
    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Run did not finish in time.");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
